>>> src/i8080_pkg.sv
// Package for the 8080 subset core: request and response types, opcode and
// register codes, controller states and the command and status structs.
// No dependencies.
package i8080_pkg;

	localparam int ADDR_BITS = 16;
	localparam int MEM_DEPTH = 1 << ADDR_BITS;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_EXEC  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [2:0] REG_B = 3'd0;
	localparam logic [2:0] REG_C = 3'd1;
	localparam logic [2:0] REG_D = 3'd2;
	localparam logic [2:0] REG_E = 3'd3;
	localparam logic [2:0] REG_H = 3'd4;
	localparam logic [2:0] REG_L = 3'd5;
	localparam logic [2:0] REG_M = 3'd6;
	localparam logic [2:0] REG_A = 3'd7;

	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_ADC = 3'd1;
	localparam logic [2:0] ALU_SUB = 3'd2;
	localparam logic [2:0] ALU_SBB = 3'd3;
	localparam logic [2:0] ALU_ANA = 3'd4;
	localparam logic [2:0] ALU_XRA = 3'd5;
	localparam logic [2:0] ALU_ORA = 3'd6;
	localparam logic [2:0] ALU_CMP = 3'd7;

	localparam logic [1:0] GRP_MISC = 2'b00;
	localparam logic [1:0] GRP_MOV  = 2'b01;
	localparam logic [1:0] GRP_ALU  = 2'b10;

	localparam logic [7:0] OP_NOP    = 8'h00;
	localparam logic [7:0] OP_LXI_B  = 8'h01;
	localparam logic [7:0] OP_LXI_D  = 8'h11;
	localparam logic [7:0] OP_STAX_B = 8'h02;
	localparam logic [7:0] OP_STAX_D = 8'h12;
	localparam logic [7:0] OP_LDAX_B = 8'h0a;
	localparam logic [7:0] OP_LDAX_D = 8'h1a;
	localparam logic [7:0] OP_INX_B  = 8'h03;
	localparam logic [7:0] OP_INX_D  = 8'h13;
	localparam logic [7:0] OP_DCX_B  = 8'h0b;
	localparam logic [7:0] OP_DCX_D  = 8'h1b;
	localparam logic [7:0] OP_INR_B  = 8'h04;
	localparam logic [7:0] OP_INR_C  = 8'h0c;
	localparam logic [7:0] OP_INR_D  = 8'h14;
	localparam logic [7:0] OP_INR_E  = 8'h1c;
	localparam logic [7:0] OP_DCR_B  = 8'h05;
	localparam logic [7:0] OP_DCR_C  = 8'h0d;
	localparam logic [7:0] OP_DCR_D  = 8'h15;
	localparam logic [7:0] OP_DCR_E  = 8'h1d;
	localparam logic [7:0] OP_MVI_B  = 8'h06;
	localparam logic [7:0] OP_MVI_C  = 8'h0e;
	localparam logic [7:0] OP_MVI_D  = 8'h16;
	localparam logic [7:0] OP_MVI_E  = 8'h1e;
	localparam logic [7:0] OP_RLC    = 8'h07;
	localparam logic [7:0] OP_RRC    = 8'h0f;
	localparam logic [7:0] OP_RAL    = 8'h17;
	localparam logic [7:0] OP_HLT    = 8'h76;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] address;
		logic [7:0]  write_byte;
	} req_t;

	typedef struct packed {
		logic [15:0] pc_out;
		logic [7:0]  reg_a;
		logic [7:0]  reg_b;
		logic [7:0]  reg_c;
		logic [7:0]  reg_d;
		logic [7:0]  reg_e;
		logic [7:0]  reg_h;
		logic [7:0]  reg_l;
		logic [3:0]  flag_bits;
		logic        halted;
		logic [7:0]  read_byte;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MEM_WR,
		S_MEM_RD,
		S_RD_CAP,
		S_FETCH,
		S_OPCODE,
		S_IMM1,
		S_IMM2,
		S_OPND,
		S_EXEC,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		AS_REQ,
		AS_PC,
		AS_PC1,
		AS_PC2,
		AS_OPND
	} addr_sel_t;

	typedef struct packed {
		addr_sel_t addr_sel;
		logic      accept;
		logic      mem_write_req;
		logic      latch_op;
		logic      latch_b1;
		logic      latch_b2;
		logic      latch_opnd;
		logic      exec;
		logic      capture_rbyte;
	} cmd_t;

	typedef struct packed {
		logic halted;
	} sts_t;

	// Flags are {sign, zero, even parity, carry}.
	function automatic logic [3:0] szp_flags(input logic [7:0] v, input logic cy);
		return {v[7], (v == 8'h00), ~^v, cy};
	endfunction

endpackage

>>> src/i8080_ctrl.sv
// Controller state machine for the 8080 subset core.
// Depends on i8080_pkg; drives the datapath through cmd_t and reads sts_t.
module i8080_ctrl import i8080_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] mode,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy,
	output logic       done
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (mode == MODE_WRITE) begin
						state_nxt = S_MEM_WR;
					end else if (mode == MODE_READ) begin
						state_nxt = S_MEM_RD;
					end else if (mode == MODE_EXEC && !sts.halted) begin
						state_nxt = S_FETCH;
					end else begin
						state_nxt = S_DONE;
					end
				end
			end
			S_MEM_WR: state_nxt = S_DONE;
			S_MEM_RD: state_nxt = S_RD_CAP;
			S_RD_CAP: state_nxt = S_DONE;
			S_FETCH:  state_nxt = S_OPCODE;
			S_OPCODE: state_nxt = S_IMM1;
			S_IMM1:   state_nxt = S_IMM2;
			S_IMM2:   state_nxt = S_OPND;
			S_OPND:   state_nxt = S_EXEC;
			S_EXEC:   state_nxt = S_DONE;
			S_DONE:   state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.addr_sel = AS_REQ;
		busy = (state_q != S_IDLE);
		done = (state_q == S_DONE);
		unique case (state_q)
			S_IDLE:   cmd.accept = start;
			S_MEM_WR: cmd.mem_write_req = 1'b1;
			S_MEM_RD: cmd.addr_sel = AS_REQ;
			S_RD_CAP: cmd.capture_rbyte = 1'b1;
			S_FETCH:  cmd.addr_sel = AS_PC;
			S_OPCODE: begin
				cmd.addr_sel = AS_PC1;
				cmd.latch_op = 1'b1;
			end
			S_IMM1: begin
				cmd.addr_sel = AS_PC2;
				cmd.latch_b1 = 1'b1;
			end
			S_IMM2: begin
				cmd.addr_sel = AS_OPND;
				cmd.latch_b2 = 1'b1;
			end
			S_OPND: begin
				cmd.addr_sel = AS_OPND;
				cmd.latch_opnd = 1'b1;
			end
			S_EXEC: begin
				cmd.addr_sel = AS_OPND;
				cmd.exec = 1'b1;
			end
			S_DONE:   cmd.addr_sel = AS_REQ;
			default:  cmd.addr_sel = AS_REQ;
		endcase
	end

endmodule

>>> src/i8080_dp.sv
// Datapath of the 8080 subset core: byte memory, register file, flags,
// instruction decode and ALU. Depends on i8080_pkg; steered by cmd_t.
module i8080_dp import i8080_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp
);

	logic [7:0] mem [MEM_DEPTH];
	logic [7:0] rdata_q;

	logic [15:0] addr_q;
	logic [7:0]  wbyte_q;
	logic [7:0]  rbyte_q;
	logic [7:0]  op_q, b1_q, b2_q, opnd_q;

	logic [15:0] pc_q;
	logic [7:0]  a_q, b_q, c_q, d_q, e_q, h_q, l_q;
	logic [3:0]  f_q;
	logic        halt_q;

	logic [15:0] n_pc;
	logic [7:0]  n_a, n_b, n_c, n_d, n_e, n_h, n_l;
	logic [3:0]  n_f;
	logic        n_halt;

	logic [15:0] pair_val, opnd_addr, addr_full;
	logic [ADDR_BITS-1:0] mem_addr;
	logic        mem_we, st_we;
	logic [7:0]  mem_wdata, st_data;
	logic [7:0]  src_val, dst_val;
	logic [8:0]  sum9, dif9;
	logic [1:0]  len;
	logic        wr_en;
	logic [2:0]  wr_code;
	logic [7:0]  wr_val;

	assign pair_val  = op_q[4] ? {d_q, e_q} : {b_q, c_q};
	assign opnd_addr = (op_q[7:6] == GRP_MISC) ? pair_val : {h_q, l_q};

	always_comb begin
		unique case (cmd.addr_sel)
			AS_REQ:  addr_full = addr_q;
			AS_PC:   addr_full = pc_q;
			AS_PC1:  addr_full = pc_q + 16'd1;
			AS_PC2:  addr_full = pc_q + 16'd2;
			AS_OPND: addr_full = opnd_addr;
			default: addr_full = addr_q;
		endcase
	end

	assign mem_addr  = addr_full[ADDR_BITS-1:0];
	assign mem_we    = cmd.mem_write_req | (cmd.exec & st_we);
	assign mem_wdata = cmd.mem_write_req ? wbyte_q : st_data;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rdata_q <= mem[mem_addr];
	end

	always_comb begin
		unique case (op_q[2:0])
			REG_B:   src_val = b_q;
			REG_C:   src_val = c_q;
			REG_D:   src_val = d_q;
			REG_E:   src_val = e_q;
			REG_H:   src_val = h_q;
			REG_L:   src_val = l_q;
			REG_M:   src_val = opnd_q;
			REG_A:   src_val = a_q;
			default: src_val = a_q;
		endcase
		unique case (op_q[5:3])
			REG_B:   dst_val = b_q;
			REG_C:   dst_val = c_q;
			REG_D:   dst_val = d_q;
			REG_E:   dst_val = e_q;
			REG_H:   dst_val = h_q;
			REG_L:   dst_val = l_q;
			REG_M:   dst_val = opnd_q;
			REG_A:   dst_val = a_q;
			default: dst_val = a_q;
		endcase
	end

	assign sum9 = {1'b0, a_q} + {1'b0, src_val}
		+ {8'd0, f_q[0] & (op_q[5:3] == ALU_ADC)};
	assign dif9 = {1'b0, a_q} - {1'b0, src_val}
		- {8'd0, f_q[0] & (op_q[5:3] == ALU_SBB)};

	always_comb begin
		n_pc = pc_q;
		n_a = a_q;
		n_b = b_q;
		n_c = c_q;
		n_d = d_q;
		n_e = e_q;
		n_h = h_q;
		n_l = l_q;
		n_f = f_q;
		n_halt = halt_q;
		st_we = 1'b0;
		st_data = src_val;
		len = 2'd1;
		wr_en = 1'b0;
		wr_code = op_q[5:3];
		wr_val = src_val;
		if (op_q == OP_HLT) begin
			n_halt = 1'b1;
		end else if (op_q[7:6] == GRP_MOV) begin
			wr_en = 1'b1;
		end else if (op_q[7:6] == GRP_ALU) begin
			unique case (op_q[5:3])
				ALU_ADD, ALU_ADC: begin
					n_a = sum9[7:0];
					n_f = szp_flags(sum9[7:0], sum9[8]);
				end
				ALU_SUB, ALU_SBB: begin
					n_a = dif9[7:0];
					n_f = szp_flags(dif9[7:0], dif9[8]);
				end
				ALU_ANA: begin
					n_a = a_q & src_val;
					n_f = szp_flags(a_q & src_val, 1'b0);
				end
				ALU_XRA: begin
					n_a = a_q ^ src_val;
					n_f = szp_flags(a_q ^ src_val, 1'b0);
				end
				ALU_ORA: begin
					n_a = a_q | src_val;
					n_f = szp_flags(a_q | src_val, 1'b0);
				end
				ALU_CMP: n_f = szp_flags(dif9[7:0], dif9[8]);
				default: n_f = f_q;
			endcase
		end else begin
			unique case (op_q)
				OP_NOP: len = 2'd1;
				OP_LXI_B, OP_LXI_D: begin
					len = 2'd3;
					if (op_q[4]) begin
						n_d = b2_q;
						n_e = b1_q;
					end else begin
						n_b = b2_q;
						n_c = b1_q;
					end
				end
				OP_STAX_B, OP_STAX_D: begin
					wr_en = 1'b1;
					wr_code = REG_M;
					wr_val = a_q;
				end
				OP_LDAX_B, OP_LDAX_D: n_a = opnd_q;
				OP_INX_B, OP_INX_D, OP_DCX_B, OP_DCX_D: begin
					if (op_q[3]) begin
						{n_b, n_c} = pair_val - 16'd1;
					end else begin
						{n_b, n_c} = pair_val + 16'd1;
					end
					if (op_q[4]) begin
						{n_d, n_e} = {n_b, n_c};
						n_b = b_q;
						n_c = c_q;
					end
				end
				OP_INR_B, OP_INR_C, OP_INR_D, OP_INR_E: begin
					wr_en = 1'b1;
					wr_val = dst_val + 8'd1;
					n_f = szp_flags(dst_val + 8'd1, f_q[0]);
				end
				OP_DCR_B, OP_DCR_C, OP_DCR_D, OP_DCR_E: begin
					wr_en = 1'b1;
					wr_val = dst_val - 8'd1;
					n_f = szp_flags(dst_val - 8'd1, f_q[0]);
				end
				OP_MVI_B, OP_MVI_C, OP_MVI_D, OP_MVI_E: begin
					len = 2'd2;
					wr_en = 1'b1;
					wr_val = b1_q;
				end
				OP_RLC: begin
					n_a = {a_q[6:0], a_q[7]};
					n_f = {f_q[3:1], a_q[7]};
				end
				OP_RRC: begin
					n_a = {a_q[0], a_q[7:1]};
					n_f = {f_q[3:1], a_q[0]};
				end
				OP_RAL: begin
					n_a = {a_q[6:0], f_q[0]};
					n_f = {f_q[3:1], a_q[7]};
				end
				default: n_halt = 1'b1;
			endcase
		end
		if (wr_en) begin
			unique case (wr_code)
				REG_B:   n_b = wr_val;
				REG_C:   n_c = wr_val;
				REG_D:   n_d = wr_val;
				REG_E:   n_e = wr_val;
				REG_H:   n_h = wr_val;
				REG_L:   n_l = wr_val;
				REG_M: begin
					st_we = 1'b1;
					st_data = wr_val;
				end
				REG_A:   n_a = wr_val;
				default: n_a = a_q;
			endcase
		end
		if (!n_halt) begin
			n_pc = pc_q + {14'd0, len};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q  <= req.address;
			wbyte_q <= req.write_byte;
		end
		if (cmd.latch_op) begin
			op_q <= rdata_q;
		end
		if (cmd.latch_b1) begin
			b1_q <= rdata_q;
		end
		if (cmd.latch_b2) begin
			b2_q <= rdata_q;
		end
		if (cmd.latch_opnd) begin
			opnd_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			e_q     <= '0;
			h_q     <= '0;
			l_q     <= '0;
			f_q     <= '0;
			halt_q  <= 1'b0;
			rbyte_q <= '0;
		end else begin
			if (cmd.exec) begin
				pc_q   <= n_pc;
				a_q    <= n_a;
				b_q    <= n_b;
				c_q    <= n_c;
				d_q    <= n_d;
				e_q    <= n_e;
				h_q    <= n_h;
				l_q    <= n_l;
				f_q    <= n_f;
				halt_q <= n_halt;
			end
			if (cmd.accept) begin
				rbyte_q <= '0;
			end else if (cmd.capture_rbyte) begin
				rbyte_q <= rdata_q;
			end
		end
	end

	assign sts.halted = halt_q;

	assign rsp.pc_out    = pc_q;
	assign rsp.reg_a     = a_q;
	assign rsp.reg_b     = b_q;
	assign rsp.reg_c     = c_q;
	assign rsp.reg_d     = d_q;
	assign rsp.reg_e     = e_q;
	assign rsp.reg_h     = h_q;
	assign rsp.reg_l     = l_q;
	assign rsp.flag_bits = f_q;
	assign rsp.halted    = halt_q;
	assign rsp.read_byte = rbyte_q;

endmodule

>>> src/i8080_move_alu_core.sv
// Top level of the 8080 subset core: controller and datapath.
// Depends on i8080_pkg, i8080_ctrl and i8080_dp.
//
// A request is taken when start is high and busy is low; done then pulses
// for one cycle with the machine state on rsp, and the receiver cannot stall
// it. Before done a memory write passes S_MEM_WR, a read S_MEM_RD
// and S_RD_CAP, an execute S_FETCH, S_OPCODE, S_IMM1, S_IMM2, S_OPND and
// S_EXEC (opcode fetch, two immediate byte reads and one operand read through
// the single memory port, then the execute step); a halted execute or mode 3
// goes straight to done. A new request can be taken in the cycle after done.
module i8080_move_alu_core import i8080_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	i8080_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (req.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	i8080_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

>>> tb/i8080_move_alu_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 8080 subset core: memory write, read and
// execute requests are predicted by an in-bench model and compared per field.
// Depends on i8080_pkg and i8080_move_alu_core.
module i8080_move_alu_core_tb;
	import i8080_pkg::*;

	localparam logic [1:0] MODE_NONE   = 2'd3;
	localparam logic [7:0] OP_UNUSED   = 8'hc3;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	i8080_move_alu_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	logic [7:0]  mem_img [0:MEM_DEPTH-1];
	bit          wr_m [0:MEM_DEPTH-1];
	logic [15:0] pc_m;
	logic [7:0]  acc_m;
	logic [7:0]  gr_m [0:5];
	logic [3:0]  fl_m;
	logic        stop_m;
	rsp_t        state_q[$];
	int          mismatches;
	int          sent;
	bit          quiet;

	function automatic logic [3:0] zsp(input logic [7:0] v, input logic cy);
		return {v[7], v == 8'h00, ~^v, cy};
	endfunction

	function automatic logic [7:0] read_reg(input logic [2:0] code);
		if (code == REG_A) return acc_m;
		if (code == REG_M) return mem_img[{gr_m[REG_H], gr_m[REG_L]}];
		return gr_m[code];
	endfunction

	function automatic void write_reg(input logic [2:0] code, input logic [7:0] v);
		if (code == REG_A) acc_m = v;
		else if (code == REG_M) begin
			mem_img[{gr_m[REG_H], gr_m[REG_L]}] = v;
			wr_m[{gr_m[REG_H], gr_m[REG_L]}] = 1'b1;
		end
		else gr_m[code] = v;
	endfunction

	function automatic void alu_op(input logic [2:0] op, input logic [7:0] x);
		logic [8:0] r;
		logic       cin;
		cin = fl_m[0];
		case (op)
			ALU_ADD: begin
				r = {1'b0, acc_m} + {1'b0, x};
				acc_m = r[7:0]; fl_m = zsp(acc_m, r[8]);
			end
			ALU_ADC: begin
				r = {1'b0, acc_m} + {1'b0, x} + {8'd0, cin};
				acc_m = r[7:0]; fl_m = zsp(acc_m, r[8]);
			end
			ALU_SUB: begin
				r = {1'b0, acc_m} - {1'b0, x};
				acc_m = r[7:0]; fl_m = zsp(acc_m, r[8]);
			end
			ALU_SBB: begin
				r = {1'b0, acc_m} - {1'b0, x} - {8'd0, cin};
				acc_m = r[7:0]; fl_m = zsp(acc_m, r[8]);
			end
			ALU_ANA: begin acc_m = acc_m & x; fl_m = zsp(acc_m, 1'b0); end
			ALU_XRA: begin acc_m = acc_m ^ x; fl_m = zsp(acc_m, 1'b0); end
			ALU_ORA: begin acc_m = acc_m | x; fl_m = zsp(acc_m, 1'b0); end
			default: begin
				r = {1'b0, acc_m} - {1'b0, x};
				fl_m = zsp(r[7:0], r[8]);
			end
		endcase
	endfunction

	function automatic int run_opcode();
		logic [7:0]  op, b1, b2, a;
		logic [2:0]  hi;
		logic [15:0] pv;
		logic [1:0]  r;
		op = mem_img[pc_m];
		b1 = mem_img[pc_m + 16'd1];
		b2 = mem_img[pc_m + 16'd2];
		hi = op[4] ? REG_D : REG_B;
		pv = {gr_m[hi], gr_m[hi + 3'd1]};
		a = acc_m;
		r = op[4:3];
		if (op[7:6] == GRP_MOV && op != OP_HLT) begin
			write_reg(op[5:3], read_reg(op[2:0]));
			return 1;
		end
		if (op[7:6] == GRP_ALU) begin
			alu_op(op[5:3], read_reg(op[2:0]));
			return 1;
		end
		case (op)
			OP_NOP: return 1;
			OP_LXI_B, OP_LXI_D: begin gr_m[hi + 3'd1] = b1; gr_m[hi] = b2; return 3; end
			OP_STAX_B, OP_STAX_D: begin
				mem_img[pv] = acc_m; wr_m[pv] = 1'b1; return 1;
			end
			OP_LDAX_B, OP_LDAX_D: begin acc_m = mem_img[pv]; return 1; end
			OP_INX_B, OP_INX_D: begin
				pv = pv + 16'd1; gr_m[hi] = pv[15:8]; gr_m[hi + 3'd1] = pv[7:0]; return 1;
			end
			OP_DCX_B, OP_DCX_D: begin
				pv = pv - 16'd1; gr_m[hi] = pv[15:8]; gr_m[hi + 3'd1] = pv[7:0]; return 1;
			end
			OP_INR_B, OP_INR_C, OP_INR_D, OP_INR_E: begin
				gr_m[r] = gr_m[r] + 8'd1; fl_m = zsp(gr_m[r], fl_m[0]); return 1;
			end
			OP_DCR_B, OP_DCR_C, OP_DCR_D, OP_DCR_E: begin
				gr_m[r] = gr_m[r] - 8'd1; fl_m = zsp(gr_m[r], fl_m[0]); return 1;
			end
			OP_MVI_B, OP_MVI_C, OP_MVI_D, OP_MVI_E: begin gr_m[r] = b1; return 2; end
			OP_RLC: begin acc_m = {a[6:0], a[7]}; fl_m[0] = a[7]; return 1; end
			OP_RRC: begin acc_m = {a[0], a[7:1]}; fl_m[0] = a[0]; return 1; end
			OP_RAL: begin acc_m = {a[6:0], fl_m[0]}; fl_m[0] = a[7]; return 1; end
			default: return 0;
		endcase
	endfunction

	function automatic rsp_t predict_state(input req_t q);
		rsp_t o;
		int   len;
		o.read_byte = 8'h00;
		if (q.mode == MODE_WRITE) begin
			mem_img[q.address] = q.write_byte;
			wr_m[q.address] = 1'b1;
		end
		else if (q.mode == MODE_READ) o.read_byte = mem_img[q.address];
		else if (q.mode == MODE_EXEC && !stop_m) begin
			len = run_opcode();
			if (len == 0) stop_m = 1'b1;
			else pc_m = pc_m + 16'(len);
		end
		o.pc_out = pc_m;
		o.reg_a = acc_m;
		o.reg_b = gr_m[REG_B];
		o.reg_c = gr_m[REG_C];
		o.reg_d = gr_m[REG_D];
		o.reg_e = gr_m[REG_E];
		o.reg_h = gr_m[REG_H];
		o.reg_l = gr_m[REG_L];
		o.flag_bits = fl_m;
		o.halted = stop_m;
		return o;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (state_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %h", rsp);
			end else begin
				rsp_t e;
				e = state_q.pop_front();
				if (rsp.pc_out !== e.pc_out || rsp.reg_a !== e.reg_a ||
					rsp.reg_b !== e.reg_b || rsp.reg_c !== e.reg_c ||
					rsp.reg_d !== e.reg_d || rsp.reg_e !== e.reg_e ||
					rsp.reg_h !== e.reg_h || rsp.reg_l !== e.reg_l ||
					rsp.flag_bits !== e.flag_bits || rsp.halted !== e.halted ||
					rsp.read_byte !== e.read_byte) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response mismatch: expected %h actual %h", e, rsp);
				end
			end
		end
	end

	// A location is written before any request can read it.
	task automatic fill_unwritten(input logic [15:0] ad);
		if (!wr_m[ad]) send_request(MODE_WRITE, ad, 8'($urandom));
	endtask

	task automatic send_request(input logic [1:0] m, input logic [15:0] ad,
			input logic [7:0] wb);
		int gap;
		req_t q;
		logic [7:0]  op;
		logic [15:0] oa;
		if (m == MODE_READ) fill_unwritten(ad);
		if (m == MODE_EXEC && !stop_m) begin
			fill_unwritten(pc_m);
			fill_unwritten(pc_m + 16'd1);
			fill_unwritten(pc_m + 16'd2);
			op = mem_img[pc_m];
			if (op[7:6] != GRP_MISC) oa = {gr_m[REG_H], gr_m[REG_L]};
			else if (op[4]) oa = {gr_m[REG_D], gr_m[REG_E]};
			else oa = {gr_m[REG_B], gr_m[REG_C]};
			fill_unwritten(oa);
		end
		gap = (!quiet && $urandom_range(0, 99) < 36) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		q.mode = m;
		q.address = ad;
		q.write_byte = wb;
		start <= 1'b1;
		req <= q;
		do @(posedge clk); while (busy);
		state_q.push_back(predict_state(q));
		sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (state_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic run_instr(input logic [7:0] op, input logic [7:0] b1,
			input logic [7:0] b2);
		send_request(MODE_WRITE, pc_m, op);
		send_request(MODE_WRITE, pc_m + 16'd1, b1);
		send_request(MODE_WRITE, pc_m + 16'd2, b2);
		send_request(MODE_EXEC, 16'($urandom), 8'($urandom));
	endtask

	function automatic logic [7:0] pick_opcode();
		logic [7:0] misc [0:25];
		logic [7:0] op;
		misc = '{OP_NOP, OP_LXI_B, OP_LXI_D, OP_STAX_B, OP_STAX_D, OP_LDAX_B,
			OP_LDAX_D, OP_INX_B, OP_INX_D, OP_DCX_B, OP_DCX_D, OP_INR_B, OP_INR_C,
			OP_INR_D, OP_INR_E, OP_DCR_B, OP_DCR_C, OP_DCR_D, OP_DCR_E, OP_MVI_B,
			OP_MVI_C, OP_MVI_D, OP_MVI_E, OP_RLC, OP_RRC, OP_RAL};
		case ($urandom_range(0, 2))
			0: begin
				op = {GRP_MOV, 3'($urandom), 3'($urandom)};
				if (op == OP_HLT) op = {GRP_MOV, REG_A, REG_M};
			end
			1: op = {GRP_ALU, 3'($urandom), 3'($urandom)};
			default: op = misc[$urandom_range(0, 25)];
		endcase
		return op;
	endfunction

	task automatic test_directed();
		send_request(MODE_READ, 16'hffff, 8'h00);
		send_request(MODE_NONE, 16'hffff, 8'hff);
		run_instr(OP_LXI_B, 8'hff, 8'hff);
		run_instr(OP_INX_B, 8'h00, 8'h00);
		run_instr(OP_DCX_B, 8'h00, 8'h00);
		run_instr(OP_LXI_D, 8'h00, 8'h80);
		run_instr(OP_DCX_D, 8'h00, 8'h00);
		run_instr(OP_MVI_E, 8'hff, 8'h00);
		run_instr(OP_INR_E, 8'h00, 8'h00);
		run_instr(OP_DCR_E, 8'h00, 8'h00);
		run_instr({GRP_ALU, ALU_SUB, REG_B}, 8'h00, 8'h00);
		run_instr(OP_RLC, 8'h00, 8'h00);
		run_instr(OP_RAL, 8'h00, 8'h00);
		run_instr(OP_RRC, 8'h00, 8'h00);
		run_instr({GRP_ALU, ALU_SBB, REG_A}, 8'h00, 8'h00);
		run_instr({GRP_ALU, ALU_ADC, REG_B}, 8'h00, 8'h00);
		run_instr({GRP_ALU, ALU_CMP, REG_D}, 8'h00, 8'h00);
		run_instr({GRP_MOV, REG_H, REG_D}, 8'h00, 8'h00);
		run_instr({GRP_MOV, REG_M, REG_A}, 8'h00, 8'h00);
		run_instr({GRP_ALU, ALU_XRA, REG_M}, 8'h00, 8'h00);
		run_instr(OP_STAX_D, 8'h00, 8'h00);
		run_instr(OP_LDAX_B, 8'h00, 8'h00);
		send_request(MODE_READ, {gr_m[REG_D], gr_m[REG_E]}, 8'h00);
	endtask

	task automatic test_random();
		logic [1:0] m;
		bit         drained;
		drained = 1'b0;
		while (sent < 1850) begin
			quiet = (sent >= 1000 && sent < 1300);
			if ($urandom_range(0, 99) < 15) begin
				m = 2'($urandom);
				if (m == MODE_EXEC) m = MODE_NONE;
				send_request(m, 16'($urandom), 8'($urandom));
			end else begin
				run_instr(pick_opcode(), 8'($urandom), 8'($urandom));
			end
			if (!drained && sent >= 900) begin
				wait_drained();
				drained = 1'b1;
			end
		end
		quiet = 0;
		wait_drained();
	endtask

	task automatic test_halt();
		run_instr(OP_UNUSED, 8'h00, 8'h00);
		send_request(MODE_EXEC, 16'h0000, 8'h00);
		send_request(MODE_WRITE, pc_m, OP_NOP);
		send_request(MODE_EXEC, 16'h0000, 8'h00);
		send_request(MODE_READ, pc_m, 8'h00);
		run_instr(OP_HLT, 8'h00, 8'h00);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		pc_m = '0;
		acc_m = '0;
		fl_m = '0;
		stop_m = 1'b0;
		for (int i = 0; i < 6; i++) gr_m[i] = '0;
		mismatches = 0;
		sent = 0;
		quiet = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_halt();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && state_q.size() == 0) begin
			$display("i8080_move_alu_core: match");
		end else begin
			$display("i8080_move_alu_core: mismatch");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("i8080_move_alu_core: mismatch");
		$finish;
	end

endmodule
